// File: rtl/core/rle_pkg.sv
// Shared types and constants for the DCT block run-length encoder.
// Used by the front end, the job queue, the byte serializer and the top level.
package rle_pkg;

    // Block position that is always treated as a zero coefficient.
    localparam logic [5:0] POS_FORCED_ZERO = 6'd62;
    // Block position that only closes the block.
    localparam logic [5:0] POS_END = 6'd63;
    // Most nonzero values carried by one run token.
    localparam logic [1:0] RUN_MAX_NONZERO = 2'd3;
    // Default number of jobs held between the front end and the serializer.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // One output job: up to four bytes, sent from index 0 up to last_idx.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            block_end;
    } rle_job_t;

endpackage

// File: rtl/core/rle_front.sv
// Front end of the run-length encoder: tracks the block position and the run state,
// and makes an output job for the DC term, for each run that a coefficient closes and for the block end.
// Depends on rle_pkg.
module rle_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [15:0]       coefficient,
    output logic              push,
    output rle_pkg::rle_job_t job
);
    import rle_pkg::*;

    logic [5:0]      pos_reg, pos_next;
    logic            collecting_reg, collecting_next;
    logic [1:0]      count_reg, count_next;
    logic [5:0]      zrun_reg, zrun_next;
    logic [2:0][7:0] pend_reg, pend_next;

    logic       is_dc;
    logic       is_end;
    logic       nonzero;
    logic [7:0] low_byte;
    logic [7:0] token;

    assign is_dc    = (pos_reg == 6'd0);
    assign is_end   = (pos_reg == POS_END);
    assign nonzero  = (pos_reg != POS_FORCED_ZERO) && (coefficient != 16'd0);
    assign low_byte = coefficient[7:0];
    assign token    = {zrun_reg, count_reg};

    // Job contents: the DC term as two bytes, otherwise the pending run.
    always_comb
    begin
        if (is_dc)
        begin
            job.bytes     = {8'd0, 8'd0, coefficient[15:8], coefficient[7:0]};
            job.last_idx  = 2'd1;
            job.block_end = 1'b0;
        end
        else
        begin
            job.bytes     = {pend_reg[2], pend_reg[1], pend_reg[0], token};
            job.last_idx  = count_reg;
            job.block_end = is_end;
        end
    end

    assign push = accept && (is_dc || is_end || (!collecting_reg && nonzero));

    // Run state update for one accepted coefficient.
    always_comb
    begin
        pos_next        = pos_reg;
        collecting_next = collecting_reg;
        count_next      = count_reg;
        zrun_next       = zrun_reg;
        pend_next       = pend_reg;
        if (accept)
        begin
            pos_next = pos_reg + 6'd1;
            if (is_dc || is_end)
            begin
                collecting_next = 1'b1;
                count_next      = 2'd0;
                zrun_next       = 6'd0;
            end
            else if (collecting_reg)
            begin
                if (nonzero)
                begin
                    case (count_reg)
                        2'd0:    pend_next[0] = low_byte;
                        2'd1:    pend_next[1] = low_byte;
                        2'd2:    pend_next[2] = low_byte;
                        default: pend_next    = pend_reg;
                    endcase
                    count_next = count_reg + 2'd1;
                    if (count_next == RUN_MAX_NONZERO)
                    begin
                        collecting_next = 1'b0;
                        zrun_next       = 6'd0;
                    end
                end
                else
                begin
                    collecting_next = 1'b0;
                    zrun_next       = 6'd1;
                end
            end
            else
            begin
                if (nonzero)
                begin
                    pend_next[0]    = low_byte;
                    count_next      = 2'd1;
                    zrun_next       = 6'd0;
                    collecting_next = 1'b1;
                end
                else
                begin
                    zrun_next = zrun_reg + 6'd1;
                end
            end
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= 6'd0;
            collecting_reg <= 1'b1;
            count_reg      <= 2'd0;
            zrun_reg       <= 6'd0;
        end
        else
        begin
            pos_reg        <= pos_next;
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            zrun_reg       <= zrun_next;
        end
    end

    // Pending nonzero values need no reset: only written entries are read.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

// File: rtl/core/rle_fifo.sv
// Short job queue between the encoder front end and the byte serializer.
// Depends on rle_pkg for the job type.
module rle_fifo #(
    parameter int DEPTH = rle_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rle_pkg::rle_job_t push_job,
    input  logic              pop,
    output rle_pkg::rle_job_t head_job,
    output logic              not_empty,
    output logic              full
);
    import rle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rle_job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = slots_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/core/rle_back.sv
// Back end of the run-length encoder: sends the bytes of each queued job one
// per cycle while out_ready allows, through a registered output stage. Depends on rle_pkg.
module rle_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  rle_pkg::rle_job_t job,
    output logic              job_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              run_last,
    output logic              block_last
);
    import rle_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       run_last_reg;
    logic       block_last_reg;
    logic       load;
    logic       last_byte;

    // A new byte enters the output register whenever it is empty or drained.
    assign load      = job_valid && (!valid_reg || out_ready);
    assign last_byte = (idx_reg == job.last_idx);
    assign job_pop   = load && last_byte;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = last_byte ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg       <= job.bytes[idx_reg];
            run_last_reg   <= last_byte;
            block_last_reg <= last_byte && job.block_end;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = run_last_reg;
    assign block_last = block_last_reg;

endmodule

// File: rtl/core/dct_block_run_length_encoder.sv
// Run-length encoder for 8x8 blocks of quantized DCT coefficients. A coefficient is
// accepted in every cycle while the job queue (QUEUE_DEPTH jobs) has room; the front
// end classifies it in the same cycle and queues at most one job of one to four bytes.
// The output side sends one byte per cycle while m_axis_tready allows it; a block of
// 64 coefficients encodes to at most 84 bytes, and the slower of the input and that
// output byte port sets the sustained rate. When the queue is empty, the first byte
// of a job passes a queue slot and then the output register. Depends on rle_pkg,
// rle_front, rle_fifo and rle_back.
module dct_block_run_length_encoder #(
    parameter int QUEUE_DEPTH = rle_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] coefficient
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // run_last
    output logic [0:0]  m_axis_tuser    // [0] block_last
);
    import rle_pkg::*;

    logic     in_accept;
    logic     push;
    logic     full;
    logic     not_empty;
    logic     pop;
    rle_job_t new_job;
    rle_job_t head_job;

    assign s_axis_tready = !full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Front end: position and run tracking.
    rle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .coefficient (s_axis_tdata),
        .push        (push),
        .job         (new_job)
    );

    // Job queue.
    rle_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (new_job),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (not_empty),
        .full      (full)
    );

    // Byte serializer.
    rle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (not_empty),
        .job        (head_job),
        .job_pop    (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .run_last   (m_axis_tlast),
        .block_last (m_axis_tuser[0])
    );

endmodule

// File: rtl/core/rle_checker.sv
// Port-level checks for the DCT block run-length encoder, bound to its top level.
// Depends only on the top level's ports.
module rle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    // Reset empties the output stage.
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

    // A stalled output transaction keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled output transaction changed");

    // The final byte of a block is also the last byte of its job.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("block end without run end");

    // Input is refused only while output work is backed up.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with idle output");

endmodule

bind dct_block_run_length_encoder rle_checker u_rle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
